// ----- hdl/mqttfh_pkg.sv -----
// Shared types and codes for the MQTT fixed-header deframer.
`default_nettype none
package mqttfh_pkg;

  localparam int unsigned LenW  = 28;
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER  = 3'd0,
    KIND_LENBYTE = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_BODY    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        pkt_type;
    logic              dup_flag;
    logic [1:0]        qos_level;
    logic              retain_flag;
    logic [LenW-1:0]   rem_len;
    logic [ByteW-1:0]  body_byte;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/mqttfh_parse.sv -----
// Packet state tracking and per-byte result decode for the deframer.
`default_nettype none
module mqttfh_parse (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   advance,
  input  wire logic [7:0]             in_byte,
  output mqttfh_pkg::result_t         res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [7:0]                     hdr_r, hdr_nxt;
  logic [mqttfh_pkg::LenW-1:0]    accum_r, accum_nxt;
  logic [2:0]                     cnt_r, cnt_nxt;
  logic [mqttfh_pkg::LenW-1:0]    left_r, left_nxt;

  logic [mqttfh_pkg::LenW-1:0]    accum_add;
  logic [mqttfh_pkg::LenW-1:0]    accum_new;
  logic [mqttfh_pkg::LenW-1:0]    left_dec;
  logic [7:0]                     hdr_src;

  // Place the seven data bits of this length byte at its base-128 digit.
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    accum_add = {21'd0, in_byte[6:0]};
      2'd1:    accum_add = {14'd0, in_byte[6:0], 7'd0};
      2'd2:    accum_add = {7'd0, in_byte[6:0], 14'd0};
      default: accum_add = {in_byte[6:0], 21'd0};
    endcase
  end

  assign accum_new = accum_r | accum_add;
  assign left_dec  = left_r - {{(mqttfh_pkg::LenW-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    hdr_src   = hdr_r;
    res.kind      = mqttfh_pkg::KIND_HEADER;
    res.rem_len   = '0;
    res.body_byte = '0;
    res.last      = 1'b0;

    case (phase_r)
      PH_LENGTH: begin
        if (cnt_r[2]) begin
          // A fifth length byte is an overlong varint.
          res.kind  = mqttfh_pkg::KIND_ERROR;
          phase_nxt = PH_HEADER;
          accum_nxt = '0;
          cnt_nxt   = '0;
          left_nxt  = '0;
        end else if (in_byte[7]) begin
          res.kind  = mqttfh_pkg::KIND_LENBYTE;
          accum_nxt = accum_new;
          cnt_nxt   = cnt_r + 3'd1;
        end else begin
          res.kind    = mqttfh_pkg::KIND_DONE;
          res.rem_len = accum_new;
          res.last    = (accum_new == '0);
          left_nxt    = accum_new;
          phase_nxt   = (accum_new == '0) ? PH_HEADER : PH_BODY;
          accum_nxt   = '0;
          cnt_nxt     = '0;
        end
      end
      PH_BODY: begin
        res.kind      = mqttfh_pkg::KIND_BODY;
        res.body_byte = in_byte;
        res.last      = (left_dec == '0);
        left_nxt      = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_HEADER;
          accum_nxt = '0;
          cnt_nxt   = '0;
        end
      end
      default: begin
        // Waiting for a header byte; fields come from the byte itself.
        hdr_src   = in_byte;
        phase_nxt = PH_HEADER;
        accum_nxt = '0;
        cnt_nxt   = '0;
        left_nxt  = '0;
        if (in_byte[7:4] == 4'd0) begin
          res.kind = mqttfh_pkg::KIND_ERROR;
        end else begin
          res.kind  = mqttfh_pkg::KIND_HEADER;
          hdr_nxt   = in_byte;
          phase_nxt = PH_LENGTH;
        end
      end
    endcase

    res.pkt_type    = hdr_src[7:4];
    res.dup_flag    = hdr_src[3];
    res.qos_level   = hdr_src[2:1];
    res.retain_flag = hdr_src[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= '0;
      accum_r <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mqttfh_out_reg.sv -----
// Result register with valid/ready handshake toward the consumer.
`default_nettype none
module mqttfh_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire mqttfh_pkg::result_t  res_in,
  input  wire logic                 out_ready,
  output logic                      can_load,
  output logic                      out_valid,
  output mqttfh_pkg::result_t       res_out
);

  logic                valid_r;
  mqttfh_pkg::result_t res_r;

  // The register may be refilled in the same cycle its item is taken.
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mqtt_fixed_header_deframer.sv -----
// MQTT fixed-header deframer: one result item for each byte item of the stream.
// The result item of an accepted byte is registered before it leaves the block.
// Throughput: one item per cycle; the result register refills in the same cycle
// that its item is taken, so input stalls only while the output is stalled.
// Reset (rst_n low, synchronous): waits for a header byte, result register empty.
`default_nettype none
module mqtt_fixed_header_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input byte stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [3:0] pkt_type, [4] dup_flag, [6:5] qos_level,
                                       // [7] retain_flag, [35:8] rem_len,
                                       // [43:36] body_byte, [47:44] zero
  output logic [2:0]       out_tuser,  // [2:0] kind
  output logic             out_tlast   // last item of the packet
);

  // Every accepted byte updates the packet state and produces exactly one
  // result item. The decode is a small combinational step from the stored
  // state and the incoming byte into the result register.
  logic                accept;
  logic                can_load;
  mqttfh_pkg::result_t res_comb;
  mqttfh_pkg::result_t res_q;

  assign in_tready = can_load;
  assign accept    = in_tvalid && in_tready;

  mqttfh_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .in_byte (in_tdata),
    .res     (res_comb)
  );

  mqttfh_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_in    (res_comb),
    .out_ready (out_tready),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .res_out   (res_q)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign out_tdata = {4'd0, res_q.body_byte, res_q.rem_len,
                      res_q.retain_flag, res_q.qos_level, res_q.dup_flag,
                      res_q.pkt_type};
  assign out_tuser = res_q.kind;
  assign out_tlast = res_q.last;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking stream testbench for the MQTT fixed-header deframer.
`default_nettype none
module tb_top;

  // Where the deframer stands in the current packet, as the predictor tracks it.
  typedef enum logic [1:0] {
    WAIT_HEADER = 2'd0,
    READ_LENGTH = 2'd1,
    IN_BODY     = 2'd2
  } deframe_phase_t;

  localparam int unsigned MaxLenBytes = 4;

  // Clock and the reset that is applied once at the start of the run.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Every input of the block starts at a known value.
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;           // [3:0] pkt_type, [4] dup_flag, [6:5] qos_level,
                                    // [7] retain_flag, [35:8] rem_len,
                                    // [43:36] body_byte, [47:44] zero
  logic [2:0]  out_tuser;           // [2:0] kind
  logic        out_tlast;

  always #4 clk = ~clk;

  mqtt_fixed_header_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Bytes still to be sent, and the result items that accepted bytes must produce,
  // oldest first.
  logic [7:0]          stream_bytes[$];
  mqttfh_pkg::result_t expected_results[$];

  // Shadow copy of the deframer's state, advanced once per accepted byte.
  deframe_phase_t              shadow_phase;
  logic [7:0]                  shadow_header;
  logic [mqttfh_pkg::LenW-1:0] shadow_accum;
  logic [2:0]                  shadow_len_count;
  logic [mqttfh_pkg::LenW-1:0] shadow_body_left;

  int unsigned         mismatch_count = 0;
  bit                  in_fire = 1'b0;
  int unsigned         in_gap = 0;
  int unsigned         out_stall = 0;
  int unsigned         quiet_left = 0;
  mqttfh_pkg::result_t got_result;
  mqttfh_pkg::result_t want_result;

  // Copies the flag fields of a header byte into a result item.
  function automatic mqttfh_pkg::result_t with_header(mqttfh_pkg::result_t r,
                                                      logic [7:0] hdr);
    r.pkt_type    = hdr[7:4];
    r.dup_flag    = hdr[3];
    r.qos_level   = hdr[2:1];
    r.retain_flag = hdr[0];
    return r;
  endfunction

  function automatic void clear_to_header_wait();
    shadow_phase     = WAIT_HEADER;
    shadow_accum     = '0;
    shadow_len_count = '0;
    shadow_body_left = '0;
  endfunction

  // Works out the result item for one accepted byte and advances the shadow state.
  function automatic mqttfh_pkg::result_t deframe_byte(logic [7:0] b);
    mqttfh_pkg::result_t r;
    r = '0;
    case (shadow_phase)
      READ_LENGTH: begin
        if (shadow_len_count >= MaxLenBytes) begin
          // A fifth length byte is an overlong length, whatever it holds.
          r = with_header(r, shadow_header);
          r.kind = mqttfh_pkg::KIND_ERROR;
          clear_to_header_wait();
        end else begin
          shadow_accum = shadow_accum | ({21'd0, b[6:0]} << (7 * shadow_len_count));
          shadow_len_count = shadow_len_count + 3'd1;
          r = with_header(r, shadow_header);
          if (b[7]) begin
            r.kind = mqttfh_pkg::KIND_LENBYTE;
          end else begin
            r.kind           = mqttfh_pkg::KIND_DONE;
            r.rem_len        = shadow_accum;
            r.last           = (shadow_accum == '0);
            shadow_body_left = shadow_accum;
            shadow_phase     = (shadow_accum == '0) ? WAIT_HEADER : IN_BODY;
            shadow_accum     = '0;
            shadow_len_count = '0;
          end
        end
      end
      IN_BODY: begin
        shadow_body_left = shadow_body_left - 1'b1;
        r = with_header(r, shadow_header);
        r.kind      = mqttfh_pkg::KIND_BODY;
        r.body_byte = b;
        r.last      = (shadow_body_left == '0);
        if (shadow_body_left == '0) clear_to_header_wait();
      end
      default: begin
        clear_to_header_wait();
        r = with_header(r, b);
        if (b[7:4] == 4'd0) begin
          // Packet type zero is reserved; the block keeps waiting for a header.
          r.kind = mqttfh_pkg::KIND_ERROR;
        end else begin
          r.kind        = mqttfh_pkg::KIND_HEADER;
          shadow_header = b;
          shadow_phase  = READ_LENGTH;
        end
      end
    endcase
    return r;
  endfunction

  // Gap length for either side: mostly none or short, now and then long, and
  // occasional quiet stretches where nobody idles at all.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 299) == 0) quiet_left = $urandom_range(40, 160);
    roll = $urandom_range(0, 999);
    if (roll < 600) return 0;
    if (roll < 900) return $urandom_range(1, 3);
    if (roll < 985) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // Queues a packet: header byte, the length as a varint spread over len_bytes
  // bytes (non-minimal encodings pad with continuation bytes), then the body.
  task automatic queue_packet(logic [7:0] hdr, int unsigned len, int unsigned len_bytes);
    logic [7:0] lb;
    stream_bytes.push_back(hdr);
    for (int unsigned i = 0; i < len_bytes; i++) begin
      lb = 8'((len >> (7 * i)) & 32'h7F);
      if (i + 1 < len_bytes) lb[7] = 1'b1;
      stream_bytes.push_back(lb);
    end
    for (int unsigned i = 0; i < len; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Fewest varint bytes that can carry a length.
  function automatic int unsigned varint_size(int unsigned len);
    if (len < 128) return 1;
    if (len < 16384) return 2;
    if (len < 2097152) return 3;
    return 4;
  endfunction

  task automatic fill_stream();
    int unsigned roll;
    int unsigned len;
    int unsigned nbytes;
    logic [7:0]  hdr;
    // Directed part. Reserved type with every flag bit set gives an error at once.
    stream_bytes.push_back(8'h0F);
    // Zero length: the completed header is itself the last item of the packet.
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'h00);
    // Short body with the extreme byte values.
    stream_bytes.push_back(8'h30);
    stream_bytes.push_back(8'h03);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'hA5);
    // Length one spread over two bytes, then over the full four.
    queue_packet(8'h1A, 1, 2);
    queue_packet(8'h82, 1, 4);
    // Overlong length: four continuation bytes and then a fifth one.
    stream_bytes.push_back(8'h65);
    repeat (4) stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'h7F);
    // A plain zero byte, reserved type with no flags.
    stream_bytes.push_back(8'h00);

    // Random part: mostly well-formed packets with random content, the rest
    // broken headers, overlong lengths and loose bytes.
    while (stream_bytes.size() < 1000) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        hdr = {4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))};
        roll = $urandom_range(0, 99);
        if (roll < 70) len = $urandom_range(0, 16);
        else if (roll < 95) len = $urandom_range(17, 140);
        else len = $urandom_range(128, 400);
        nbytes = varint_size(len);
        if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(nbytes, MaxLenBytes);
        queue_packet(hdr, len, nbytes);
      end else if (roll < 85) begin
        stream_bytes.push_back({4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))});
        repeat (4) stream_bytes.push_back(8'($urandom_range(128, 255)));
        stream_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (roll < 92) begin
        stream_bytes.push_back({4'd0, 4'($urandom_range(0, 15))});
      end else begin
        repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end

    // The largest length the varint can carry goes last, since its body never
    // ends within the run; a few body bytes follow it.
    stream_bytes.push_back(8'hF0);
    repeat (3) stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'h7F);
    repeat (3) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Driver: offers the next byte once the current one has been taken, with
  // random gaps between items. Changes happen on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (stream_bytes.size() > 0) begin
        in_tdata  <= stream_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side: ready is dropped for random stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall = pick_gap();
    end
  end

  // Monitor: on each rising edge, first check a result item leaving the block,
  // then predict the result for a byte entering it. The result seen at this edge
  // always belongs to an earlier byte, so this order keeps the queue straight.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_result.kind        = mqttfh_pkg::kind_t'(out_tuser);
        got_result.pkt_type    = out_tdata[3:0];
        got_result.dup_flag    = out_tdata[4];
        got_result.qos_level   = out_tdata[6:5];
        got_result.retain_flag = out_tdata[7];
        got_result.rem_len     = out_tdata[35:8];
        got_result.body_byte   = out_tdata[43:36];
        got_result.last        = out_tlast;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result item: kind %0d tdata %h last %b",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.kind !== want_result.kind ||
              got_result.pkt_type !== want_result.pkt_type ||
              got_result.dup_flag !== want_result.dup_flag ||
              got_result.qos_level !== want_result.qos_level ||
              got_result.retain_flag !== want_result.retain_flag ||
              got_result.rem_len !== want_result.rem_len ||
              got_result.body_byte !== want_result.body_byte ||
              got_result.last !== want_result.last ||
              out_tdata[47:44] !== 4'd0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch at %0t", $time);
              $display("  expected kind %0d type %h dup %b qos %0d retain %b",
                       want_result.kind, want_result.pkt_type, want_result.dup_flag,
                       want_result.qos_level, want_result.retain_flag);
              $display("           len %0d body %h last %b",
                       want_result.rem_len, want_result.body_byte, want_result.last);
              $display("  actual   kind %0d type %h dup %b qos %0d retain %b",
                       out_tuser, got_result.pkt_type, got_result.dup_flag,
                       got_result.qos_level, got_result.retain_flag);
              $display("           len %0d body %h last %b pad %h",
                       got_result.rem_len, got_result.body_byte, out_tlast,
                       out_tdata[47:44]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) expected_results.push_back(deframe_byte(in_tdata));
    end
  end

  // Main sequence: reset once, let the stream drain, then give the verdict.
  initial begin
    shadow_header = '0;
    clear_to_header_wait();
    fill_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (stream_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // Wait on so that any stray result item is caught as well.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with every gap at its longest.
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
